FILE: sv/irac_pkg.sv
// irac_pkg: shared types, constants and the digit-to-character function
// for the integer to radix ascii unit. no dependencies.
package irac_pkg;

  localparam int NUMBER_W = 64;
  localparam int RADIX_W  = 6;
  localparam int WIDTH_W  = 6;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] TEN        = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH,
    ST_PAD_PRE,
    ST_SIGN,
    ST_FETCH,
    ST_DIGIT,
    ST_PAD_POST
  } irac_state_t;

  typedef struct packed {
    logic load;
    logic again;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               quot_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] d8;
    d8 = CHAR_W'(d);
    if (d8 < TEN) return ZERO_CHAR + d8;
    else if (upper) return UPPER_A + d8 - TEN;
    else return LOWER_A + d8 - TEN;
  endfunction

endpackage

FILE: sv/irac_in_if.sv
// irac_in_if: input channel carrying one number and its format options per word.
// depends on irac_pkg for field widths.
interface irac_in_if;
  logic                           valid;
  logic                           ready;
  logic [irac_pkg::NUMBER_W-1:0]  number;
  logic                           is_signed;
  logic [irac_pkg::RADIX_W-1:0]   radix;
  logic [irac_pkg::WIDTH_W-1:0]   min_digits;
  logic [irac_pkg::CHAR_W-1:0]    pad_char;
  logic                           pad_after;
  logic                           upper_case;

  modport source (output valid, number, is_signed, radix, min_digits, pad_char,
                  pad_after, upper_case, input ready);
  modport sink (input valid, number, is_signed, radix, min_digits, pad_char,
                pad_after, upper_case, output ready);
endinterface

FILE: sv/irac_out_if.sv
// irac_out_if: output channel carrying one ascii character and a last flag per beat.
// depends on irac_pkg for field widths.
interface irac_out_if;
  logic                        valid;
  logic                        ready;
  logic [irac_pkg::CHAR_W-1:0] ascii_char;
  logic                        last;

  modport source (output valid, ascii_char, last, input ready);
  modport sink (input valid, ascii_char, last, output ready);
endinterface

FILE: sv/integer_to_radix_ascii_unit.sv
// integer_to_radix_ascii_unit: formats one integer per word as ascii characters.
// each digit is formed in the bit-serial divider; then come a setup state, a pad state
// for each pad character, a sign state for a negative value and a read and an emit per digit.
// one number at a time: a new word is taken only in idle, once the last character of
// the word before is emitted; the output can hold off any pad, sign or digit character.
// reset (synchronous, rst_n low) clears the sequencer, digit count and output valid;
// the digit store is not cleared.
module integer_to_radix_ascii_unit #(
  parameter int DIGIT_SLOTS = 32,
  parameter int VALUE_BITS  = 64
) (
  input logic        clk,
  input logic        rst_n,
  irac_in_if.sink    in_ch,
  irac_out_if.source out_ch
);
  import irac_pkg::*;

  localparam int CW = $clog2(DIGIT_SLOTS + 1);
  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam int PW = (CW > WIDTH_W) ? CW : WIDTH_W;
  localparam logic [CW-1:0] SLOTS = CW'(DIGIT_SLOTS);

  irac_state_t state_r, state_nxt;

  // item fields held for the whole word
  logic                  neg_r, neg_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [WIDTH_W-1:0]    width_r, width_nxt;
  logic [CHAR_W-1:0]     pad_r, pad_nxt;
  logic                  left_r, left_nxt;
  logic                  upper_r, upper_nxt;
  logic [VALUE_BITS-1:0] value_in, magnitude;
  logic                  sign_in;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         dig_r, dig_nxt;
  logic [WIDTH_W-1:0]    pad_cnt_r, pad_cnt_nxt;
  logic [WIDTH_W-1:0]    padn;
  logic [PW-1:0]         width_ext, cnt_ext;

  logic [DIGIT_W-1:0]    digit_store_r [DIGIT_SLOTS];
  logic [DIGIT_W-1:0]    rd_digit_r;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept, can_load, emit, emit_last;
  logic [CHAR_W-1:0]     emit_char;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;

  irac_serial_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (magnitude),
    .radix    (radix_nxt),
    .stat     (div_stat)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;
  assign value_in = in_ch.number[VALUE_BITS-1:0];
  assign sign_in  = in_ch.is_signed && value_in[VALUE_BITS-1];
  assign magnitude = sign_in ? (~value_in + VALUE_BITS'(1)) : value_in;

  assign width_ext = PW'(width_r);
  assign cnt_ext   = PW'(cnt_r);
  assign padn      = (width_ext > cnt_ext) ? WIDTH_W'(width_ext - cnt_ext) : '0;

  assign rd_addr = AW'(dig_r - CW'(1));
  assign wr_addr = cnt_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:      if (div_stat.done && div_stat.quot_zero) state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!left_r && padn != '0) state_nxt = ST_PAD_PRE;
        else if (neg_r) state_nxt = ST_SIGN;
        else state_nxt = ST_FETCH;
      end
      ST_PAD_PRE: begin
        if (can_load && pad_cnt_r == WIDTH_W'(1)) state_nxt = neg_r ? ST_SIGN : ST_FETCH;
      end
      ST_SIGN:     if (can_load) state_nxt = ST_FETCH;
      ST_FETCH:    state_nxt = ST_DIGIT;
      ST_DIGIT: begin
        if (can_load) begin
          if (dig_r != CW'(1)) state_nxt = ST_FETCH;
          else if (pad_cnt_r != '0) state_nxt = ST_PAD_POST;
          else state_nxt = ST_IDLE;
        end
      end
      ST_PAD_POST: if (can_load && pad_cnt_r == WIDTH_W'(1)) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready    = 1'b0;
    div_ctrl.load  = 1'b0;
    div_ctrl.again = 1'b0;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_char      = pad_r;
    emit_last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready   = 1'b1;
        div_ctrl.load = in_ch.valid;
      end
      ST_DIV: begin
        wr_en          = div_stat.done && (cnt_r < SLOTS);
        div_ctrl.again = div_stat.done && !div_stat.quot_zero;
      end
      ST_PAD_PRE: emit = can_load;
      ST_SIGN: begin
        emit      = can_load;
        emit_char = MINUS_CHAR;
      end
      ST_DIGIT: begin
        emit      = can_load;
        emit_char = digit_char(rd_digit_r, upper_r);
        emit_last = (dig_r == CW'(1)) && (pad_cnt_r == '0);
      end
      ST_PAD_POST: begin
        emit      = can_load;
        emit_last = (pad_cnt_r == WIDTH_W'(1));
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    neg_nxt     = neg_r;
    radix_nxt   = radix_r;
    width_nxt   = width_r;
    pad_nxt     = pad_r;
    left_nxt    = left_r;
    upper_nxt   = upper_r;
    cnt_nxt     = cnt_r;
    dig_nxt     = dig_r;
    pad_cnt_nxt = pad_cnt_r;
    if (accept) begin
      neg_nxt   = sign_in;
      if (in_ch.radix < RADIX_MIN) radix_nxt = RADIX_MIN;
      else if (in_ch.radix > RADIX_MAX) radix_nxt = RADIX_MAX;
      else radix_nxt = in_ch.radix;
      width_nxt = in_ch.min_digits;
      pad_nxt   = (in_ch.pad_char == '0) ? SPACE_CHAR : in_ch.pad_char;
      left_nxt  = in_ch.pad_after;
      upper_nxt = in_ch.upper_case;
      cnt_nxt   = '0;
    end
    if (state_r == ST_DIV && div_stat.done && cnt_r < SLOTS) cnt_nxt = cnt_r + CW'(1);
    if (state_r == ST_FINISH) begin
      dig_nxt     = cnt_r;
      pad_cnt_nxt = padn;
    end
    if (emit && (state_r == ST_PAD_PRE || state_r == ST_PAD_POST))
      pad_cnt_nxt = pad_cnt_r - WIDTH_W'(1);
    if (emit && state_r == ST_DIGIT) dig_nxt = dig_r - CW'(1);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dig_r       <= '0;
      pad_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dig_r       <= dig_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    radix_r    <= radix_nxt;
    width_r    <= width_nxt;
    pad_r      <= pad_nxt;
    left_r     <= left_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit store, least significant digit at the lowest address
  always_ff @(posedge clk) begin
    if (wr_en) digit_store_r[wr_addr] <= div_stat.digit;
  end

  always_ff @(posedge clk) begin
    rd_digit_r <= digit_store_r[rd_addr];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last       = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOTS)
    else $error("digit count beyond store depth");

  a_digit_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT || state_r == ST_FETCH) |-> (dig_r != '0))
    else $error("digit read with empty pointer");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DIV && cnt_r == '0))
    else $error("accepted word did not start division");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == ST_IDLE && out_ch.last))
    else $error("last character did not end the word");

endmodule

FILE: sv/irac_serial_div.sv
// irac_serial_div: bit-serial restoring divider by a small radix, one quotient
// bit per cycle, quotient shifts back into the dividend register. uses irac_pkg.
module irac_serial_div #(
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irac_pkg::div_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [irac_pkg::RADIX_W-1:0]  radix,
  output irac_pkg::div_stat_t           stat
);
  import irac_pkg::*;

  localparam int BW = $clog2(VALUE_BITS);
  localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] v_r, v_nxt, v_step;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt, rem_step;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic                  busy_r, busy_nxt;
  logic [DIGIT_W:0]      trial;
  logic                  ge;

  always_comb begin
    trial    = {rem_r, v_r[VALUE_BITS-1]};
    ge       = trial >= {1'b0, radix};
    rem_step = ge ? DIGIT_W'(trial - {1'b0, radix}) : trial[DIGIT_W-1:0];
    v_step   = {v_r[VALUE_BITS-2:0], ge};
  end

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (ctrl.load) begin
      v_nxt    = dividend;
      rem_nxt  = '0;
      bit_nxt  = LAST_BIT;
      busy_nxt = 1'b1;
    end else if (ctrl.again) begin
      // next digit: divide the quotient just formed
      v_nxt    = v_step;
      rem_nxt  = '0;
      bit_nxt  = LAST_BIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt   = v_step;
      rem_nxt = rem_step;
      bit_nxt = bit_r - BW'(1);
      if (bit_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done      = busy_r && (bit_r == '0);
  assign stat.digit     = rem_step;
  assign stat.quot_zero = (v_step == '0);

endmodule
